FILE: sv/sensor_batch_frame_builder_defines.svh
// ============================================================================
// Sensor batch frame builder assertion macros
// Shared macros for the concurrent assertions of the frame builder checker.
// ============================================================================
`ifndef SENSOR_BATCH_FRAME_BUILDER_DEFINES_SVH
`define SENSOR_BATCH_FRAME_BUILDER_DEFINES_SVH

// Assertion on aclk that is switched off while reset is held.
`define SBFB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Assertion on aclk that also checks behaviour across reset.
`define SBFB_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: sv/sbfb_pkg.sv
// ============================================================================
// Sensor batch frame builder package
// Types, constants and the CRC-8 step shared by the frame builder modules.
// ============================================================================
package sbfb_pkg;

    // CRC-8 polynomial x^8 + x^2 + x + 1, initial value zero.
    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_INIT = 8'h00;

    // Configuration register indexes.
    localparam logic [2:0] REG_SYNC_FIRST    = 3'd0;
    localparam logic [2:0] REG_SYNC_SECOND   = 3'd1;
    localparam logic [2:0] REG_CODE_NONE     = 3'd2;
    localparam logic [2:0] REG_CODE_ADC      = 3'd3;
    localparam logic [2:0] REG_CODE_OXIMETER = 3'd4;

    // Configuration reset values.
    localparam logic [7:0] RST_SYNC_FIRST    = 8'h00;
    localparam logic [7:0] RST_SYNC_SECOND   = 8'h00;
    localparam logic [7:0] RST_CODE_NONE     = 8'h00;
    localparam logic [7:0] RST_CODE_ADC      = 8'h01;
    localparam logic [7:0] RST_CODE_OXIMETER = 8'h02;

    // Header byte positions; the timestamp fills the last four.
    localparam logic [2:0] HDR_SYNC_FIRST  = 3'd0;
    localparam logic [2:0] HDR_SYNC_SECOND = 3'd1;
    localparam logic [2:0] HDR_TYPE        = 3'd2;
    localparam logic [2:0] HDR_COUNT       = 3'd3;
    localparam logic [2:0] HDR_LAST        = 3'd7;

    // Payload bytes per sample.
    localparam logic [3:0] ADC_BYTES = 4'd6;
    localparam logic [3:0] OXI_BYTES = 4'd10;
    localparam logic [3:0] NO_BYTES  = 4'd0;

    // Control of the CRC unit for one cycle.
    typedef struct packed {
        logic       clear;
        logic       update;
        logic [7:0] data;
    } sbfb_crc_ctrl_t;

    // One byte of CRC-8, MSB first, no reflection.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: sv/sensor_batch_frame_builder.sv
// A sample that closes no batch passes the accept, check and store states.
// A frame streams one byte per cycle while m_ready is high: 9 + 6 or 10 bytes per sample.
// Throughput is set by the byte sequencer and its shared CRC unit; output back-pressure
// stalls the frame byte stream.
// Reset (aresetn low, synchronous) restores the register defaults and empties the batch.
// ============================================================================
// Sensor batch frame builder
// Groups samples of one type into batches and streams each batch as a
// byte frame with header, payload and CRC-8.
// ============================================================================
module sensor_batch_frame_builder #(
    parameter int BATCH_SIZE = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Sample channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_sensor_type,
    input  logic [31:0] s_sample_time,
    input  logic [15:0] s_emg_average,
    input  logic [15:0] s_eeg_average,
    input  logic [15:0] s_ekg_average,
    input  logic signed [31:0] s_oxygen_saturation,
    input  logic [7:0]  s_oxygen_valid,
    input  logic signed [31:0] s_heart_rate,
    input  logic [7:0]  s_rate_valid,
    // Frame byte channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_byte,
    output logic        m_frame_end,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int IDX_W = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_STORE = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_HDR   = 3'd4;
    localparam logic [2:0] ST_PAY   = 3'd5;
    localparam logic [2:0] ST_CRC   = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [7:0]  sync_first_reg, sync_second_reg, code_none_reg, code_adc_reg, code_oxi_reg;
    logic [2:0]  count_reg, count_next;
    logic [7:0]  batch_type_reg, batch_type_next;
    logic [31:0] batch_time_reg, batch_time_next;
    logic        ret_store_reg, ret_store_next;
    logic [2:0]  hdr_idx_reg, hdr_idx_next;
    logic [2:0]  samp_reg, samp_next;
    logic [3:0]  pay_byte_reg, pay_byte_next;

    // Held sample.
    logic [7:0]  item_type_reg, item_type_next;
    logic [31:0] item_time_reg, item_time_next;
    logic [47:0] item_adc_reg, item_adc_next;
    logic [79:0] item_oxi_reg, item_oxi_next;

    // Sample stores.
    logic [47:0] adc_store_reg [BATCH_SIZE];
    logic [79:0] oxi_store_reg [BATCH_SIZE];
    logic        adc_we, oxi_we;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_byte_reg, m_byte_next;
    logic        m_end_reg, m_end_next;

    sbfb_pkg::sbfb_crc_ctrl_t crc_ctrl;
    logic [7:0]  crc_value;

    logic        out_free;
    logic [3:0]  pay_len;
    logic [7:0]  hdr_byte;
    logic [7:0]  pay_byte_val;
    logic [IDX_W-1:0] wr_idx, rd_idx;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_frame_byte = m_byte_reg;
    assign m_frame_end  = m_end_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign wr_idx   = count_reg[IDX_W-1:0];
    assign rd_idx   = samp_reg[IDX_W-1:0];

    // Payload length per sample follows the batch type.
    always_comb begin
        if (batch_type_reg == code_adc_reg) begin
            pay_len = sbfb_pkg::ADC_BYTES;
        end else if (batch_type_reg == code_oxi_reg) begin
            pay_len = sbfb_pkg::OXI_BYTES;
        end else begin
            pay_len = sbfb_pkg::NO_BYTES;
        end
    end

    // Header byte for the current header position.
    always_comb begin
        case (hdr_idx_reg)
            sbfb_pkg::HDR_SYNC_FIRST:  hdr_byte = sync_first_reg;
            sbfb_pkg::HDR_SYNC_SECOND: hdr_byte = sync_second_reg;
            sbfb_pkg::HDR_TYPE:        hdr_byte = batch_type_reg;
            sbfb_pkg::HDR_COUNT:       hdr_byte = {5'b00000, count_reg};
            default:                   hdr_byte = 8'(batch_time_reg >> {hdr_idx_reg[1:0], 3'b000});
        endcase
    end

    // Payload byte, little endian within each stored sample.
    always_comb begin
        if (batch_type_reg == code_adc_reg) begin
            pay_byte_val = 8'(adc_store_reg[rd_idx] >> {pay_byte_reg, 3'b000});
        end else begin
            pay_byte_val = 8'(oxi_store_reg[rd_idx] >> {pay_byte_reg, 3'b000});
        end
    end

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        batch_type_next = batch_type_reg;
        batch_time_next = batch_time_reg;
        ret_store_next  = ret_store_reg;
        hdr_idx_next    = hdr_idx_reg;
        samp_next       = samp_reg;
        pay_byte_next   = pay_byte_reg;
        item_type_next  = item_type_reg;
        item_time_next  = item_time_reg;
        item_adc_next   = item_adc_reg;
        item_oxi_next   = item_oxi_reg;
        m_byte_next     = m_byte_reg;
        m_end_next      = m_end_reg;
        m_valid_next    = m_ready ? 1'b0 : m_valid_reg;
        adc_we          = 1'b0;
        oxi_we          = 1'b0;
        crc_ctrl        = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_type_next = s_sensor_type;
                    item_time_next = s_sample_time;
                    item_adc_next  = {s_ekg_average, s_eeg_average, s_emg_average};
                    item_oxi_next  = {s_rate_valid, s_heart_rate, s_oxygen_valid,
                                      s_oxygen_saturation};
                    state_next     = ST_CHECK;
                end
            end
            // A type change closes the open batch before the sample is stored.
            ST_CHECK: begin
                if (count_reg != 3'd0 && item_type_reg != batch_type_reg) begin
                    if (batch_type_reg == code_none_reg) begin
                        count_next = 3'd0;
                        state_next = ST_STORE;
                    end else begin
                        crc_ctrl.clear = 1'b1;
                        hdr_idx_next   = sbfb_pkg::HDR_SYNC_FIRST;
                        ret_store_next = 1'b1;
                        state_next     = ST_HDR;
                    end
                end else begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                if (count_reg == 3'd0) begin
                    batch_type_next = item_type_reg;
                    batch_time_next = item_time_reg;
                end
                if (item_type_reg == code_adc_reg) begin
                    adc_we = 1'b1;
                end else if (item_type_reg == code_oxi_reg) begin
                    oxi_we = 1'b1;
                end
                count_next = 3'(count_reg + 3'd1);
                if (3'(count_reg + 3'd1) == 3'(BATCH_SIZE)) begin
                    state_next = ST_FULL;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            // A full batch is flushed after the sample is stored.
            ST_FULL: begin
                if (batch_type_reg == code_none_reg) begin
                    count_next = 3'd0;
                    state_next = ST_IDLE;
                end else begin
                    crc_ctrl.clear = 1'b1;
                    hdr_idx_next   = sbfb_pkg::HDR_SYNC_FIRST;
                    ret_store_next = 1'b0;
                    state_next     = ST_HDR;
                end
            end
            ST_HDR: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_byte_next     = hdr_byte;
                    m_end_next      = 1'b0;
                    crc_ctrl.data   = hdr_byte;
                    crc_ctrl.update = (hdr_idx_reg[2:1] != 2'b00);
                    if (hdr_idx_reg == sbfb_pkg::HDR_LAST) begin
                        samp_next     = 3'd0;
                        pay_byte_next = 4'd0;
                        state_next    = (pay_len == sbfb_pkg::NO_BYTES) ? ST_CRC : ST_PAY;
                    end else begin
                        hdr_idx_next = 3'(hdr_idx_reg + 3'd1);
                    end
                end
            end
            ST_PAY: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_byte_next     = pay_byte_val;
                    m_end_next      = 1'b0;
                    crc_ctrl.data   = pay_byte_val;
                    crc_ctrl.update = 1'b1;
                    if (pay_byte_reg == 4'(pay_len - 4'd1)) begin
                        pay_byte_next = 4'd0;
                        samp_next     = 3'(samp_reg + 3'd1);
                        if (3'(samp_reg + 3'd1) == count_reg) begin
                            state_next = ST_CRC;
                        end
                    end else begin
                        pay_byte_next = 4'(pay_byte_reg + 4'd1);
                    end
                end
            end
            ST_CRC: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = crc_value;
                    m_end_next   = 1'b1;
                    count_next   = 3'd0;
                    state_next   = ret_store_reg ? ST_STORE : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            count_reg       <= 3'd0;
            batch_type_reg  <= 8'h00;
            batch_time_reg  <= 32'h0;
            ret_store_reg   <= 1'b0;
            hdr_idx_reg     <= 3'd0;
            samp_reg        <= 3'd0;
            pay_byte_reg    <= 4'd0;
            m_valid_reg     <= 1'b0;
            sync_first_reg  <= sbfb_pkg::RST_SYNC_FIRST;
            sync_second_reg <= sbfb_pkg::RST_SYNC_SECOND;
            code_none_reg   <= sbfb_pkg::RST_CODE_NONE;
            code_adc_reg    <= sbfb_pkg::RST_CODE_ADC;
            code_oxi_reg    <= sbfb_pkg::RST_CODE_OXIMETER;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            batch_type_reg <= batch_type_next;
            batch_time_reg <= batch_time_next;
            ret_store_reg  <= ret_store_next;
            hdr_idx_reg    <= hdr_idx_next;
            samp_reg       <= samp_next;
            pay_byte_reg   <= pay_byte_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    sbfb_pkg::REG_SYNC_FIRST:    sync_first_reg  <= cfg_data;
                    sbfb_pkg::REG_SYNC_SECOND:   sync_second_reg <= cfg_data;
                    sbfb_pkg::REG_CODE_NONE:     code_none_reg   <= cfg_data;
                    sbfb_pkg::REG_CODE_ADC:      code_adc_reg    <= cfg_data;
                    sbfb_pkg::REG_CODE_OXIMETER: code_oxi_reg    <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers: held sample, output byte and sample stores.
    always_ff @(posedge aclk) begin
        item_type_reg <= item_type_next;
        item_time_reg <= item_time_next;
        item_adc_reg  <= item_adc_next;
        item_oxi_reg  <= item_oxi_next;
        m_byte_reg    <= m_byte_next;
        m_end_reg     <= m_end_next;
        if (adc_we) begin
            adc_store_reg[wr_idx] <= item_adc_reg;
        end
        if (oxi_we) begin
            oxi_store_reg[wr_idx] <= item_oxi_reg;
        end
    end

    // CRC over every frame byte after the sync bytes.
    sbfb_crc_unit u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (crc_ctrl),
        .crc     (crc_value)
    );

endmodule

FILE: sv/sbfb_crc_unit.sv
// ============================================================================
// Frame CRC unit
// Accumulates the CRC-8 of the frame, one byte per cycle in which update is set.
// ============================================================================
module sbfb_crc_unit (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  sbfb_pkg::sbfb_crc_ctrl_t ctrl,
    output logic [7:0]              crc
);

    logic [7:0] crc_reg;
    logic [7:0] crc_next;

    // Clear at the start of a frame, fold in each covered byte.
    always_comb begin
        crc_next = crc_reg;
        if (ctrl.clear) begin
            crc_next = sbfb_pkg::CRC_INIT;
        end else if (ctrl.update) begin
            crc_next = sbfb_pkg::crc8_update(crc_reg, ctrl.data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= sbfb_pkg::CRC_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

FILE: sv/sbfb_checker.sv
// ============================================================================
// Sensor batch frame builder checker
// Port-level assertions on the frame builder, bound to the top level.
// ============================================================================
`include "sensor_batch_frame_builder_defines.svh"

module sbfb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_frame_byte,
    input logic       m_frame_end,
    input logic       cfg_ready
);

    // A stalled frame byte holds its value.
    `SBFB_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_frame_byte) && $stable(m_frame_end), "frame byte changed while stalled")

    // Each sample passes the check and store states, so ready drops after a transaction.
    `SBFB_ASSERT(a_busy_after_accept, s_valid && s_ready |=> !s_ready, "sample taken on consecutive cycles")

    // No frame byte is shown right after reset.
    `SBFB_ASSERT_RST(a_reset_quiet, !aresetn |=> !m_valid, "frame byte valid after reset")

    // Configuration writes are always taken.
    `SBFB_ASSERT(a_cfg_ready, cfg_ready, "configuration port not ready")

endmodule

bind sensor_batch_frame_builder sbfb_checker u_sbfb_checker (.*);

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// Sensor batch frame builder testbench
// Drives sensor samples and register writes into the frame builder, predicts
// every frame byte from its own model of the batching, and checks each byte
// of the frame channel in order under several idling and stall patterns.
// ============================================================================
module testbench;

    localparam int BATCH         = 4;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 25;
    localparam int NUM_PHASES    = 5;

    // One sensor sample as presented on the input channel.
    typedef struct {
        logic [7:0]         sensor_type;
        logic [31:0]        sample_time;
        logic [15:0]        emg_average;
        logic [15:0]        eeg_average;
        logic [15:0]        ekg_average;
        logic signed [31:0] oxygen_saturation;
        logic [7:0]         oxygen_valid;
        logic signed [31:0] heart_rate;
        logic [7:0]         rate_valid;
    } sample_t;

    // Predicts the frames built from accepted samples and checks the byte stream.
    class frame_scoreboard;
        logic [7:0]  sync_first, sync_second, code_none, code_adc, code_oxi;
        int unsigned batch_len;
        logic [7:0]  batch_type;
        logic [31:0] batch_start;
        logic [47:0] adc_samples [BATCH];
        logic [39:0] spo2_samples [BATCH];
        logic [39:0] pulse_samples [BATCH];
        logic [8:0]  frame_bytes [$];
        int          errors;
        int          samples_taken;
        int          bytes_checked;
        int          frames_checked;

        function new();
            sync_first  = 8'h00;
            sync_second = 8'h00;
            code_none   = 8'h00;
            code_adc    = 8'h01;
            code_oxi    = 8'h02;
            batch_len   = 0;
            batch_type  = 8'h00;
            batch_start = 32'h0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [7:0] val);
            case (idx)
                sbfb_pkg::REG_SYNC_FIRST:    sync_first  = val;
                sbfb_pkg::REG_SYNC_SECOND:   sync_second = val;
                sbfb_pkg::REG_CODE_NONE:     code_none   = val;
                sbfb_pkg::REG_CODE_ADC:      code_adc    = val;
                sbfb_pkg::REG_CODE_OXIMETER: code_oxi    = val;
                default: ;
            endcase
        endfunction

        // Builds the frame of the open batch and queues its bytes.
        function void close_frame();
            logic [7:0] body [$];
            logic [7:0] crc;
            if (batch_len == 0 || batch_type == code_none) return;
            body.push_back(batch_type);
            body.push_back(8'(batch_len));
            for (int k = 0; k < 4; k++) body.push_back(batch_start[8*k +: 8]);
            for (int i = 0; i < int'(batch_len); i++) begin
                if (batch_type == code_adc) begin
                    for (int k = 0; k < 6; k++) body.push_back(adc_samples[i][8*k +: 8]);
                end else if (batch_type == code_oxi) begin
                    for (int k = 0; k < 5; k++) body.push_back(spo2_samples[i][8*k +: 8]);
                    for (int k = 0; k < 5; k++) body.push_back(pulse_samples[i][8*k +: 8]);
                end
            end
            // CRC-8 over everything after the sync bytes, shifted MSB first.
            crc = 8'h00;
            foreach (body[i]) begin
                crc = crc ^ body[i];
                repeat (8) crc = {crc[6:0], 1'b0} ^ (crc[7] ? 8'h07 : 8'h00);
            end
            frame_bytes.push_back({1'b0, sync_first});
            frame_bytes.push_back({1'b0, sync_second});
            foreach (body[i]) frame_bytes.push_back({1'b0, body[i]});
            frame_bytes.push_back({1'b1, crc});
        endfunction

        // Notes one accepted sample: a type change closes the batch first,
        // a full batch closes after the sample is stored.
        function void note_sample(sample_t smp);
            samples_taken++;
            if (batch_len != 0 && smp.sensor_type != batch_type) begin
                close_frame();
                batch_len = 0;
            end
            if (batch_len == 0) begin
                batch_type  = smp.sensor_type;
                batch_start = smp.sample_time;
            end
            if (smp.sensor_type == code_adc) begin
                adc_samples[batch_len] = {smp.ekg_average, smp.eeg_average, smp.emg_average};
            end else if (smp.sensor_type == code_oxi) begin
                spo2_samples[batch_len]  = {smp.oxygen_valid, smp.oxygen_saturation};
                pulse_samples[batch_len] = {smp.rate_valid, smp.heart_rate};
            end
            batch_len++;
            if (batch_len >= BATCH) begin
                close_frame();
                batch_len = 0;
            end
        endfunction

        function void check_byte(logic [7:0] frame_byte, logic frame_end);
            logic [8:0] want;
            if (frame_bytes.size() == 0) begin
                $error("frame_byte: expected nothing, got %02h (frame_end %0b)",
                       frame_byte, frame_end);
                errors++;
                return;
            end
            want = frame_bytes.pop_front();
            bytes_checked++;
            if (want[8]) frames_checked++;
            if (frame_byte !== want[7:0]) begin
                $error("frame_byte: expected %02h, got %02h", want[7:0], frame_byte);
                errors++;
            end
            if (frame_end !== want[8]) begin
                $error("frame_end: expected %0b, got %0b", want[8], frame_end);
                errors++;
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_sensor_type;
    logic [31:0]        s_sample_time;
    logic [15:0]        s_emg_average;
    logic [15:0]        s_eeg_average;
    logic [15:0]        s_ekg_average;
    logic signed [31:0] s_oxygen_saturation;
    logic [7:0]         s_oxygen_valid;
    logic signed [31:0] s_heart_rate;
    logic [7:0]         s_rate_valid;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [7:0]         m_frame_byte;
    logic               m_frame_end;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [7:0]         cfg_data;

    frame_scoreboard    sb;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 hold_len = 0;
    int                 hold_left = 0;
    logic               hold_armed = 1'b1;
    int                 cycle_count = 0;
    int                 settings_applied = 0;

    sensor_batch_frame_builder #(
        .BATCH_SIZE(BATCH)
    ) dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_sensor_type       (s_sensor_type),
        .s_sample_time       (s_sample_time),
        .s_emg_average       (s_emg_average),
        .s_eeg_average       (s_eeg_average),
        .s_ekg_average       (s_ekg_average),
        .s_oxygen_saturation (s_oxygen_saturation),
        .s_oxygen_valid      (s_oxygen_valid),
        .s_heart_rate        (s_heart_rate),
        .s_rate_valid        (s_rate_valid),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_frame_byte        (m_frame_byte),
        .m_frame_end         (m_frame_end),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Run limit in case the block hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Frame channel receiver: a long hold-off when asked, otherwise random stalls.
    // The hold-off is requested once and counted down here.
    always @(negedge aclk) begin
        if (hold_armed && hold_len > 0) begin
            hold_left  = hold_len;
            hold_armed = 1'b0;
        end
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Every frame byte transaction is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_byte(m_frame_byte, m_frame_end);
    end

    function automatic sample_t make_sample(logic [7:0] t, logic [31:0] ts,
                                            logic [15:0] emg, logic [15:0] eeg,
                                            logic [15:0] ekg, logic [31:0] spo2,
                                            logic [7:0] ov, logic [31:0] rate,
                                            logic [7:0] rv);
        sample_t smp;
        smp.sensor_type       = t;
        smp.sample_time       = ts;
        smp.emg_average       = emg;
        smp.eeg_average       = eeg;
        smp.ekg_average       = ekg;
        smp.oxygen_saturation = spo2;
        smp.oxygen_valid      = ov;
        smp.heart_rate        = rate;
        smp.rate_valid        = rv;
        return smp;
    endfunction

    function automatic sample_t random_sample(logic [7:0] t);
        return make_sample(t, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                           $urandom, 8'($urandom), $urandom, 8'($urandom));
    endfunction

    // Offers one sample after a random gap and waits for its transaction.
    // Entered and left just after a falling edge.
    task automatic send_sample(input sample_t smp);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_sensor_type       = smp.sensor_type;
        s_sample_time       = smp.sample_time;
        s_emg_average       = smp.emg_average;
        s_eeg_average       = smp.eeg_average;
        s_ekg_average       = smp.ekg_average;
        s_oxygen_saturation = smp.oxygen_saturation;
        s_oxygen_valid      = smp.oxygen_valid;
        s_heart_rate        = smp.heart_rate;
        s_rate_valid        = smp.rate_valid;
        s_valid             = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(smp);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_settings(input logic [7:0] sf, input logic [7:0] ss,
                                  input logic [7:0] cn, input logic [7:0] ca,
                                  input logic [7:0] co);
        write_reg(sbfb_pkg::REG_SYNC_FIRST, sf);
        write_reg(sbfb_pkg::REG_SYNC_SECOND, ss);
        write_reg(sbfb_pkg::REG_CODE_NONE, cn);
        write_reg(sbfb_pkg::REG_CODE_ADC, ca);
        write_reg(sbfb_pkg::REG_CODE_OXIMETER, co);
        settings_applied++;
    endtask

    // Fills the open batch with its own type so that no sample is left
    // pending across a change of the type codes.
    task automatic close_batch();
        while (sb.batch_len != 0) send_sample(random_sample(sb.batch_type));
        s_valid = 1'b0;
    endtask

    // Waits for every predicted byte, then for the block to go quiet.
    task automatic settle();
        while (sb.frame_bytes.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Random sample runs: mostly batches of the configured types, some noise.
    task automatic random_phase(input int items);
        int         sent;
        int         run;
        int         pick;
        logic [7:0] t;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      t = sb.code_adc;
            else if (pick < 75) t = sb.code_oxi;
            else if (pick < 85) t = sb.code_none;
            else                t = 8'($urandom);
            run = $urandom_range(1, BATCH + 1);
            for (int j = 0; j < run && sent < items; j++) begin
                send_sample(random_sample(t));
                sent++;
            end
        end
        close_batch();
    endtask

    initial begin
        sb = new();
        aresetn             = 1'b0;
        s_valid             = 1'b0;
        s_sensor_type       = 8'h00;
        s_sample_time       = 32'h0;
        s_emg_average       = 16'h0;
        s_eeg_average       = 16'h0;
        s_ekg_average       = 16'h0;
        s_oxygen_saturation = 32'sh0;
        s_oxygen_valid      = 8'h00;
        s_heart_rate        = 32'sh0;
        s_rate_valid        = 8'h00;
        cfg_valid           = 1'b0;
        cfg_index           = sbfb_pkg::REG_SYNC_FIRST;
        cfg_data            = 8'h00;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // Directed part under the reset register values, no idling.
        // A full ADC batch with all-zero and all-one fields.
        send_sample(make_sample(8'h01, 32'h0, 16'h0000, 16'hFFFF, 16'h0000,
                                32'h0, 8'h00, 32'h0, 8'h00));
        send_sample(make_sample(8'h01, 32'h1, 16'hFFFF, 16'h0000, 16'hFFFF,
                                32'h0, 8'h00, 32'h0, 8'h00));
        send_sample(make_sample(8'h01, 32'h2, 16'h8000, 16'h7FFF, 16'h0001,
                                32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF, 8'hFF));
        send_sample(make_sample(8'h01, 32'h3, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                32'h0, 8'h00, 32'h0, 8'h00));
        // A short ADC batch closed by a change to the oximeter type.
        send_sample(make_sample(8'h01, 32'hFFFFFFFF, 16'h1234, 16'h5678, 16'h9ABC,
                                32'h0, 8'h00, 32'h0, 8'h00));
        send_sample(make_sample(8'h01, 32'hFFFFFFFE, 16'h0000, 16'h0000, 16'h0000,
                                32'h0, 8'h00, 32'h0, 8'h00));
        // A full oximeter batch with the signed extremes.
        send_sample(make_sample(8'h02, 32'hFFFFFFFF, 16'h0, 16'h0, 16'h0,
                                32'h80000000, 8'h00, 32'h7FFFFFFF, 8'hFF));
        send_sample(make_sample(8'h02, 32'h0, 16'h0, 16'h0, 16'h0,
                                32'h7FFFFFFF, 8'hFF, 32'h80000000, 8'h00));
        send_sample(make_sample(8'h02, 32'h5, 16'h0, 16'h0, 16'h0,
                                32'hFFFFFFFF, 8'h80, 32'h0, 8'h01));
        send_sample(make_sample(8'h02, 32'h6, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                32'h0, 8'h01, 32'hFFFFFFFF, 8'h80));
        // No-sensor samples are dropped; other types give empty payloads.
        send_sample(random_sample(8'h00));
        send_sample(random_sample(8'h00));
        send_sample(random_sample(8'hFF));
        send_sample(random_sample(8'h80));
        send_sample(random_sample(8'h01));
        send_sample(random_sample(8'h02));
        send_sample(random_sample(8'h00));
        close_batch();
        settle();

        // Random phases, each under its own registers and idling pattern.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    apply_settings(8'hFF, 8'h00, 8'h00, 8'h01, 8'h02);
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_len       = 400;
                end
                1: begin
                    apply_settings(8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80);
                    send_idle_pct  = 61;
                    recv_stall_pct = 0;
                end
                2: begin
                    // ADC and oximeter share one code; the ADC form wins.
                    apply_settings(8'hA5, 8'h5A, 8'h44, 8'h33, 8'h33);
                    send_idle_pct  = 0;
                    recv_stall_pct = 61;
                end
                3: begin
                    // No-sensor and ADC share one code; such batches are dropped.
                    apply_settings(8'h3C, 8'hC3, 8'h21, 8'h21, 8'h7E);
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                end
                default: begin
                    apply_settings(8'($urandom), 8'($urandom), 8'($urandom),
                                   8'($urandom), 8'($urandom));
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                end
            endcase
            random_phase(PHASE_ITEMS);
            settle();
        end

        $display("Run covered %0d samples, %0d frames of %0d bytes, %0d register settings.",
                 sb.samples_taken, sb.frames_checked, sb.bytes_checked, settings_applied);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
